// ===== src/afcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_pkg
// Shared types and constants of the addressed frame command responder.
// ----------------------------------------------------------------------------
package afcr_pkg;

    localparam logic [7:0]  START_BYTE = 8'h7E;
    localparam logic [7:0]  END_BYTE   = 8'h0D;
    localparam logic [7:0]  PAD_BYTE   = 8'h00;
    localparam logic [7:0]  ADDR_RESET = 8'h01;

    localparam logic [15:0] CMD_OPEN   = 16'h1001;
    localparam logic [15:0] CMD_CARD   = 16'h1002;
    localparam logic [15:0] CMD_RESET  = 16'h1003;

    localparam int          STORE_DEPTH = 7;
    localparam int          REPLY_HEAD  = 6;

    // Reply byte index within the nine-byte reply.
    localparam logic [3:0]  IDX_ZERO   = 4'd6;
    localparam logic [3:0]  IDX_END    = 4'd7;
    localparam logic [3:0]  IDX_LAST   = 4'd8;

    // Parse positions with special meaning.
    localparam logic [2:0]  POS_HUNT   = 3'd0;
    localparam logic [2:0]  POS_ADDR   = 3'd1;
    localparam logic [2:0]  POS_DATA   = 3'd4;
    localparam logic [2:0]  POS_CMD_HI = 3'd5;
    localparam logic [2:0]  POS_MODE   = 3'd6;
    localparam logic [2:0]  POS_SAT    = 3'd7;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CARD  = 2'd2,
        ACT_RESET = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_VERIFY    = 2'd0,
        MODE_ADD       = 2'd1,
        MODE_DELETE    = 2'd2,
        MODE_UNCHANGED = 2'd3
    } t_card_mode;

    // One pending reply: a snapshot of the frame head and the decoded command.
    typedef struct packed {
        logic [REPLY_HEAD-1:0][7:0] head;
        t_action                    action;
        t_card_mode                 mode;
    } t_job;

endpackage

// ===== src/afcr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_front
// Frame parser: hunts the start byte, checks the station address, stores
// the frame head and decodes the command when the end byte arrives.
// ----------------------------------------------------------------------------
module afcr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_job_push,
    output afcr_pkg::t_job   o_job
);

    logic [7:0] r_station_addr;
    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [afcr_pkg::STORE_DEPTH-1:0][7:0] r_fb;
    logic [afcr_pkg::STORE_DEPTH-1:0][7:0] n_fb;
    logic       store_en;
    logic       frame_end;
    logic [15:0] cmd;

    always_comb begin
        n_pos     = r_pos;
        store_en  = 1'b0;
        frame_end = 1'b0;
        if (r_pos == afcr_pkg::POS_HUNT) begin
            if (i_rx_byte == afcr_pkg::START_BYTE) begin
                store_en = 1'b1;
                n_pos    = afcr_pkg::POS_ADDR;
            end
        end else if (r_pos == afcr_pkg::POS_ADDR) begin
            if (i_rx_byte == r_station_addr) begin
                store_en = 1'b1;
                n_pos    = r_pos + 3'd1;
            end else begin
                n_pos = afcr_pkg::POS_HUNT;
            end
        end else if (r_pos < afcr_pkg::POS_DATA) begin
            // Length bytes are stored unchecked, even when they look like an end byte.
            store_en = 1'b1;
            n_pos    = r_pos + 3'd1;
        end else if (i_rx_byte != afcr_pkg::END_BYTE) begin
            store_en = (r_pos != afcr_pkg::POS_SAT);
            n_pos    = (r_pos == afcr_pkg::POS_SAT) ? afcr_pkg::POS_SAT : r_pos + 3'd1;
        end else begin
            store_en  = (r_pos != afcr_pkg::POS_SAT);
            frame_end = 1'b1;
            n_pos     = afcr_pkg::POS_HUNT;
        end
    end

    always_comb begin
        n_fb = r_fb;
        if (store_en) begin
            n_fb[r_pos] = i_rx_byte;
        end
    end

    // The decode sees the end byte when it lands inside the command or mode bytes.
    assign cmd = {n_fb[afcr_pkg::POS_CMD_HI], n_fb[afcr_pkg::POS_DATA]};

    always_comb begin
        o_job.head   = n_fb[afcr_pkg::REPLY_HEAD-1:0];
        o_job.mode   = afcr_pkg::MODE_UNCHANGED;
        o_job.action = afcr_pkg::ACT_NONE;
        case (cmd)
            afcr_pkg::CMD_OPEN:  o_job.action = afcr_pkg::ACT_OPEN;
            afcr_pkg::CMD_CARD: begin
                o_job.action = afcr_pkg::ACT_CARD;
                if (n_fb[afcr_pkg::POS_MODE] <= 8'd2) begin
                    o_job.mode = afcr_pkg::t_card_mode'(n_fb[afcr_pkg::POS_MODE][1:0]);
                end
            end
            afcr_pkg::CMD_RESET: o_job.action = afcr_pkg::ACT_RESET;
            default:             o_job.action = afcr_pkg::ACT_NONE;
        endcase
    end

    assign o_job_push = i_accept && frame_end && (o_job.action != afcr_pkg::ACT_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_addr <= afcr_pkg::ADDR_RESET;
            r_pos          <= afcr_pkg::POS_HUNT;
            r_fb           <= '0;
        end else begin
            if (i_cfg_we) begin
                r_station_addr <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_pos <= n_pos;
                r_fb  <= n_fb;
            end
        end
    end

endmodule

// ===== src/afcr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_fifo
// Two-entry queue of pending replies between the parser and the sender.
// ----------------------------------------------------------------------------
module afcr_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  afcr_pkg::t_job   i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output afcr_pkg::t_job   o_job
);

    afcr_pkg::t_job r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== src/afcr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcr_back
// Reply sender: walks the nine bytes of the oldest pending reply into an
// output register, one byte per transaction.
// ----------------------------------------------------------------------------
module afcr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  afcr_pkg::t_job   i_job,
    output logic             o_job_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_reply_byte,
    output logic             o_reply_last,
    output logic [1:0]       o_action,
    output logic [1:0]       o_card_mode
);

    logic        r_valid;
    logic [3:0]  r_idx;
    logic [7:0]  r_byte;
    logic        r_last;
    afcr_pkg::t_action    r_action;
    afcr_pkg::t_card_mode r_mode;
    logic        load;
    logic [7:0]  sel_byte;

    assign load      = i_job_valid && (!r_valid || i_pop);
    assign o_job_pop = load && (r_idx == afcr_pkg::IDX_LAST);

    always_comb begin
        case (r_idx)
            afcr_pkg::IDX_ZERO: sel_byte = afcr_pkg::PAD_BYTE;
            afcr_pkg::IDX_END:  sel_byte = afcr_pkg::END_BYTE;
            afcr_pkg::IDX_LAST: sel_byte = afcr_pkg::PAD_BYTE;
            default: begin
                if (r_idx < afcr_pkg::IDX_ZERO) begin
                    sel_byte = i_job.head[r_idx[2:0]];
                end else begin
                    sel_byte = afcr_pkg::PAD_BYTE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= sel_byte;
            r_last   <= (r_idx == afcr_pkg::IDX_LAST);
            r_action <= (r_idx == 4'd0) ? i_job.action : afcr_pkg::ACT_NONE;
            r_mode   <= (r_idx == 4'd0) ? i_job.mode : afcr_pkg::MODE_UNCHANGED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= (r_idx == afcr_pkg::IDX_LAST) ? 4'd0 : r_idx + 4'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty      = !r_valid;
    assign o_reply_byte = r_byte;
    assign o_reply_last = r_last;
    assign o_action     = r_action;
    assign o_card_mode  = r_mode;

endmodule

// ===== src/addressed_frame_command_responder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_frame_command_responder
// Parses addressed bus frames and queues a nine-byte reply for each frame
// that closes with a known command.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        i_rx_byte
//  reply     empty / pop        o_reply_byte, o_reply_last, o_action, o_card_mode
//  config    i_cfg_we           i_cfg_wdata (station address)
//
// The parser takes one byte per cycle while full is low; a closing end byte is
// decoded in the same cycle and its reply is written into the queue, then loaded
// into the sender's output register. The sender gives one reply byte per cycle
// while pop is high and a reply waits, nine per reply. Up to two replies wait in
// the queue; full rises only while both slots are taken. Reset is synchronous.
// ----------------------------------------------------------------------------
module addressed_frame_command_responder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_reply_byte,
    output logic       o_reply_last,
    output logic [1:0] o_action,
    output logic [1:0] o_card_mode
);

    logic           accept;
    logic           job_push;
    afcr_pkg::t_job job_in;
    logic           job_valid;
    afcr_pkg::t_job job_out;
    logic           job_pop;

    assign accept = push && !full;

    afcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    afcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (job_out)
    );

    afcr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (job_out),
        .o_job_pop    (job_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_reply_byte (o_reply_byte),
        .o_reply_last (o_reply_last),
        .o_action     (o_action),
        .o_card_mode  (o_card_mode)
    );

endmodule

// ===== tb/sv/addressed_frame_command_responder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_frame_command_responder_tb
// Self-checking bench for the frame responder. Received bytes are pushed from
// a queue with random gaps while a predictor parses the same byte stream and
// queues the reply bytes it expects. Each popped reply byte is compared with
// the oldest expected one. The station address is rewritten between phases,
// and at one point the reply side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module addressed_frame_command_responder_tb;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_PER_SET = 55;
    localparam int DIRECTED_LEN   = 27;

    // Length bytes that look like an end byte, a mismatched address after a
    // start, a short frame and a long card mode frame.
    localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
        afcr_pkg::START_BYTE, afcr_pkg::ADDR_RESET, afcr_pkg::END_BYTE, afcr_pkg::END_BYTE,
        afcr_pkg::CMD_OPEN[7:0], afcr_pkg::CMD_OPEN[15:8], 8'h02, afcr_pkg::END_BYTE,
        afcr_pkg::START_BYTE, afcr_pkg::START_BYTE, afcr_pkg::START_BYTE,
        afcr_pkg::ADDR_RESET, 8'hFF, 8'h00,
        afcr_pkg::CMD_RESET[7:0], afcr_pkg::CMD_RESET[15:8], afcr_pkg::END_BYTE,
        afcr_pkg::START_BYTE, afcr_pkg::ADDR_RESET, 8'h00, 8'h00,
        afcr_pkg::CMD_CARD[7:0], afcr_pkg::CMD_CARD[15:8],
        8'(afcr_pkg::MODE_ADD), 8'hAA, 8'h55, afcr_pkg::END_BYTE
    };

    typedef struct {
        logic [7:0]           data;
        logic                 last;
        afcr_pkg::t_action    act;
        afcr_pkg::t_card_mode mode;
    } t_reply_beat;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       push        = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_reply_byte;
    logic       o_reply_last;
    logic [1:0] o_action;
    logic [1:0] o_card_mode;

    logic [7:0]  rx_pending [$];
    t_reply_beat reply_expect [$];

    // Predictor state.
    logic [7:0] model_addr = afcr_pkg::ADDR_RESET;
    logic [2:0] parse_pos  = afcr_pkg::POS_HUNT;
    logic [7:0] frame_store [afcr_pkg::STORE_DEPTH] = '{default: 8'h00};

    logic [7:0] cur_addr       = afcr_pkg::ADDR_RESET;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;
    bit         hold_request   = 1'b0;
    bit         hold_done      = 1'b0;
    int         hold_left      = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    addressed_frame_command_responder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .empty        (empty),
        .pop          (pop),
        .o_reply_byte (o_reply_byte),
        .o_reply_last (o_reply_last),
        .o_action     (o_action),
        .o_card_mode  (o_card_mode)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Parses one accepted byte and queues the nine reply bytes of a frame
    // that closes with a known command.
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [15:0]          cmd;
        afcr_pkg::t_action    act;
        afcr_pkg::t_card_mode mode;
        t_reply_beat          beat;
        if (parse_pos == afcr_pkg::POS_HUNT) begin
            if (b == afcr_pkg::START_BYTE) begin
                frame_store[0] = b;
                parse_pos = afcr_pkg::POS_ADDR;
            end
        end else if (parse_pos == afcr_pkg::POS_ADDR) begin
            if (b == model_addr) begin
                frame_store[1] = b;
                parse_pos = parse_pos + 3'd1;
            end else begin
                parse_pos = afcr_pkg::POS_HUNT;
            end
        end else if (parse_pos < afcr_pkg::POS_DATA) begin
            frame_store[parse_pos] = b;
            parse_pos = parse_pos + 3'd1;
        end else if (b != afcr_pkg::END_BYTE) begin
            if (parse_pos != afcr_pkg::POS_SAT) begin
                frame_store[parse_pos] = b;
                parse_pos = parse_pos + 3'd1;
            end
        end else begin
            if (parse_pos != afcr_pkg::POS_SAT) begin
                frame_store[parse_pos] = b;
            end
            parse_pos = afcr_pkg::POS_HUNT;
            cmd = {frame_store[5], frame_store[4]};
            mode = afcr_pkg::MODE_UNCHANGED;
            case (cmd)
                afcr_pkg::CMD_OPEN: act = afcr_pkg::ACT_OPEN;
                afcr_pkg::CMD_CARD: begin
                    act = afcr_pkg::ACT_CARD;
                    if (frame_store[6] <= 8'(afcr_pkg::MODE_DELETE)) begin
                        mode = afcr_pkg::t_card_mode'(frame_store[6][1:0]);
                    end
                end
                afcr_pkg::CMD_RESET: act = afcr_pkg::ACT_RESET;
                default: act = afcr_pkg::ACT_NONE;
            endcase
            if (act != afcr_pkg::ACT_NONE) begin
                for (int k = 0; k <= int'(afcr_pkg::IDX_LAST); k++) begin
                    if (k < afcr_pkg::REPLY_HEAD) begin
                        beat.data = frame_store[k];
                    end else begin
                        beat.data = (k == int'(afcr_pkg::IDX_END)) ? afcr_pkg::END_BYTE
                                                                   : afcr_pkg::PAD_BYTE;
                    end
                    beat.last = (k == int'(afcr_pkg::IDX_LAST));
                    beat.act  = (k == 0) ? act : afcr_pkg::ACT_NONE;
                    beat.mode = (k == 0) ? mode : afcr_pkg::MODE_UNCHANGED;
                    reply_expect.push_back(beat);
                end
            end
        end
    endtask

    // Byte sender: offers the oldest pending byte unless it idles this cycle.
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_pending.size() == 0) begin
            push <= 1'b0;
        end else if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
        end else begin
            push      <= 1'b1;
            i_rx_byte <= rx_pending[0];
        end
    end

    // Reply receiver, with one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            pop <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: both transactions are seen at the rising edge.
    always @(posedge i_clk) begin
        t_reply_beat want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                model_addr = i_cfg_wdata;
            end
            if (push && !full) begin
                void'(rx_pending.pop_front());
                parse_rx_byte(i_rx_byte);
            end
            if (pop && !empty) begin
                if (reply_expect.size() == 0) begin
                    $error("unexpected reply byte %0h", o_reply_byte);
                    mismatch_count++;
                end else begin
                    want = reply_expect.pop_front();
                    if (o_reply_byte !== want.data) begin
                        $error("reply_byte: expected %0h, actual %0h", want.data, o_reply_byte);
                        mismatch_count++;
                    end
                    if (o_reply_last !== want.last) begin
                        $error("reply_last: expected %0h, actual %0h", want.last, o_reply_last);
                        mismatch_count++;
                    end
                    if (o_action !== want.act) begin
                        $error("action: expected %0h, actual %0h", want.act, o_action);
                        mismatch_count++;
                    end
                    if (o_card_mode !== want.mode) begin
                        $error("card_mode: expected %0h, actual %0h", want.mode, o_card_mode);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic write_station_addr(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        cur_addr = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (rx_pending.size() != 0 || reply_expect.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_data_byte();
        logic [7:0] x;
        x = 8'($urandom);
        return (x == afcr_pkg::END_BYTE) ? 8'hFF : x;
    endfunction

    // Mostly well-formed frames with random content, plus noise, broken
    // addresses and frames that end early.
    task automatic queue_random_frame();
        int         kind;
        int         n;
        logic [7:0] body [3];
        kind = $urandom_range(99);
        if (kind < 12) begin
            n = $urandom_range(1, 6);
            repeat (n) rx_pending.push_back(8'($urandom));
            return;
        end
        rx_pending.push_back(afcr_pkg::START_BYTE);
        if (kind < 18) begin
            rx_pending.push_back(cur_addr ^ 8'($urandom_range(1, 255)));
            return;
        end
        rx_pending.push_back(cur_addr);
        repeat (2) begin
            rx_pending.push_back(($urandom_range(99) < 15) ? afcr_pkg::END_BYTE
                                                           : 8'($urandom));
        end
        body[0] = ($urandom_range(99) < 80)
                  ? afcr_pkg::CMD_OPEN[7:0] + 8'($urandom_range(0, 2))
                  : 8'($urandom);
        body[1] = ($urandom_range(99) < 85) ? afcr_pkg::CMD_OPEN[15:8] : 8'($urandom);
        body[2] = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        n = (kind < 28) ? $urandom_range(0, 2) : 3;
        for (int k = 0; k < n; k++) begin
            rx_pending.push_back(body[k]);
        end
        if (n == 3) begin
            repeat ($urandom_range(0, 3)) rx_pending.push_back(rand_data_byte());
        end
        rx_pending.push_back(afcr_pkg::END_BYTE);
    endtask

    task automatic run_random_set(input logic [7:0] addr);
        int queued;
        write_station_addr(addr);
        queued = 0;
        while (queued < RANDOM_PER_SET) begin
            n_before_update: begin
                int size_prior;
                size_prior = rx_pending.size();
                queue_random_frame();
                queued += rx_pending.size() - size_prior;
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 38;
        recv_idle_pct = 52;
        foreach (DIRECTED_BYTES[k]) rx_pending.push_back(DIRECTED_BYTES[k]);
        wait_drained();
        run_random_set(afcr_pkg::ADDR_RESET);
        run_random_set(8'hFF);

        send_idle_pct = 52;
        recv_idle_pct = 38;
        run_random_set(8'h00);
        run_random_set(afcr_pkg::START_BYTE);

        // No idling here; the long hold-off backs replies up into the input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        run_random_set(8'($urandom));
        run_random_set(afcr_pkg::END_BYTE);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/afcr_pkg.sv
src/afcr_front.sv
src/afcr_fifo.sv
src/afcr_back.sv
src/addressed_frame_command_responder.sv
tb/sv/addressed_frame_command_responder_tb.sv
